// ===== rtl/pcr_pkg.sv =====
package pcr_pkg;

    // field widths of the request and the result
    localparam int FIELD_BITS     = 16;
    localparam int COUNT_BITS     = 16;
    localparam int VALUE_BITS_DEF = 16;

    // first trial divisor
    localparam int FIRST_DIVISOR = 2;

    // microprogram step address
    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] t_step;

    localparam t_step S_IDLE  = 4'd0;
    localparam t_step S_RANGE = 4'd1;
    localparam t_step S_SMALL = 4'd2;
    localparam t_step S_SQ    = 4'd3;
    localparam t_step S_DIV   = 4'd4;
    localparam t_step S_TEST  = 4'd5;
    localparam t_step S_PRIME = 4'd6;
    localparam t_step S_NEXT  = 4'd7;
    localparam t_step S_DONE  = 4'd8;

    // branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_NO_REQ   = 3'd1,
        C_V_GE_HI  = 3'd2,
        C_V_LT2    = 3'd3,
        C_DSQ_GT_V = 3'd4,
        C_DIV_MORE = 3'd5,
        C_REM_NZ   = 3'd6,
        C_OUT_BUSY = 3'd7
    } t_cond;

    // one control word
    typedef struct packed {
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
        logic  ld_req;
        logic  init_d;
        logic  start_div;
        logic  div_step;
        logic  inc_d;
        logic  inc_cnt;
        logic  inc_v;
        logic  ld_out;
    } t_ctrl;

    // flags from the datapath
    typedef struct packed {
        logic v_ge_hi;
        logic v_lt2;
        logic dsq_gt_v;
        logic div_more;
        logic rem_nz;
    } t_dp_status;

    // control store
    function automatic t_ctrl pcr_ucode(input t_step step);
        t_ctrl w;
        begin
            w = '0;
            unique case (step)
                S_IDLE: begin
                    w.cond = C_NO_REQ;   w.jmp_t = S_IDLE;  w.jmp_f = S_RANGE;
                    w.ld_req = 1'b1;
                end
                S_RANGE: begin
                    w.cond = C_V_GE_HI;  w.jmp_t = S_DONE;  w.jmp_f = S_SMALL;
                end
                S_SMALL: begin
                    w.cond = C_V_LT2;    w.jmp_t = S_NEXT;  w.jmp_f = S_SQ;
                    w.init_d = 1'b1;
                end
                S_SQ: begin
                    w.cond = C_DSQ_GT_V; w.jmp_t = S_PRIME; w.jmp_f = S_DIV;
                    w.start_div = 1'b1;
                end
                S_DIV: begin
                    w.cond = C_DIV_MORE; w.jmp_t = S_DIV;   w.jmp_f = S_TEST;
                    w.div_step = 1'b1;
                end
                S_TEST: begin
                    w.cond = C_REM_NZ;   w.jmp_t = S_SQ;    w.jmp_f = S_NEXT;
                    w.inc_d = 1'b1;
                end
                S_PRIME: begin
                    w.cond = C_ALWAYS;   w.jmp_t = S_NEXT;  w.jmp_f = S_NEXT;
                    w.inc_cnt = 1'b1;
                end
                S_NEXT: begin
                    w.cond = C_ALWAYS;   w.jmp_t = S_RANGE; w.jmp_f = S_RANGE;
                    w.inc_v = 1'b1;
                end
                S_DONE: begin
                    w.cond = C_OUT_BUSY; w.jmp_t = S_DONE;  w.jmp_f = S_IDLE;
                    w.ld_out = 1'b1;
                end
                default: begin
                    w.cond = C_ALWAYS;   w.jmp_t = S_IDLE;  w.jmp_f = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/pcr_useq.sv =====
module pcr_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_out_busy,
    input  pcr_pkg::t_dp_status i_dp_status,
    output pcr_pkg::t_ctrl      o_ctrl,
    output logic                o_idle
);

    pcr_pkg::t_step r_step;
    pcr_pkg::t_step n_step;
    pcr_pkg::t_ctrl w_word;
    logic           w_take;

    // control store fetch
    assign w_word = pcr_pkg::pcr_ucode(r_step);

    // branch condition select
    always_comb begin
        unique case (w_word.cond)
            pcr_pkg::C_ALWAYS:   w_take = 1'b1;
            pcr_pkg::C_NO_REQ:   w_take = !i_req_valid;
            pcr_pkg::C_V_GE_HI:  w_take = i_dp_status.v_ge_hi;
            pcr_pkg::C_V_LT2:    w_take = i_dp_status.v_lt2;
            pcr_pkg::C_DSQ_GT_V: w_take = i_dp_status.dsq_gt_v;
            pcr_pkg::C_DIV_MORE: w_take = i_dp_status.div_more;
            pcr_pkg::C_REM_NZ:   w_take = i_dp_status.rem_nz;
            pcr_pkg::C_OUT_BUSY: w_take = i_out_busy;
            default:             w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.jmp_t : w_word.jmp_f;
    end

    // request load and result load only fire on the handshake
    always_comb begin
        o_ctrl        = w_word;
        o_ctrl.ld_req = w_word.ld_req && i_req_valid;
        o_ctrl.ld_out = w_word.ld_out && !i_out_busy;
    end

    assign o_idle = (r_step == pcr_pkg::S_IDLE);

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pcr_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== rtl/pcr_datapath.sv =====
module pcr_datapath #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcr_pkg::t_ctrl                     i_ctrl,
    input  logic [pcr_pkg::FIELD_BITS-1:0]     i_range_start,
    input  logic [pcr_pkg::FIELD_BITS-1:0]     i_range_end,
    output pcr_pkg::t_dp_status                o_dp_status,
    output logic [pcr_pkg::COUNT_BITS-1:0]     o_count
);

    // values are bounded by both the parameter and the field width
    localparam int VW = (VALUE_BITS < pcr_pkg::FIELD_BITS) ? VALUE_BITS : pcr_pkg::FIELD_BITS;
    localparam int SW = VW + 2;
    localparam int BW = $clog2(VW + 1);
    localparam int CW = pcr_pkg::COUNT_BITS;

    logic [VW-1:0] r_v;
    logic [VW-1:0] r_hi;
    logic [VW-1:0] r_d;
    logic [SW-1:0] r_dsq;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_q;
    logic [BW-1:0] r_bits;
    logic [CW-1:0] r_cnt;

    logic [VW:0]   w_trial;
    logic          w_ge;
    logic [VW-1:0] n_rem;

    // one restoring remainder step
    always_comb begin
        w_trial = {r_rem, r_q[VW-1]};
        w_ge    = (w_trial >= {1'b0, r_d});
        n_rem   = w_ge ? VW'(w_trial - {1'b0, r_d}) : w_trial[VW-1:0];
    end

    // candidate, bound and count
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_req) begin
            r_v   <= i_range_start[VW-1:0];
            r_hi  <= i_range_end[VW-1:0];
            r_cnt <= '0;
        end else begin
            if (i_ctrl.inc_v) begin
                r_v <= r_v + VW'(1);
            end
            if (i_ctrl.inc_cnt) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // divisor and its square, kept by adding 2d+1
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init_d) begin
            r_d   <= VW'(pcr_pkg::FIRST_DIVISOR);
            r_dsq <= SW'(pcr_pkg::FIRST_DIVISOR * pcr_pkg::FIRST_DIVISOR);
        end else if (i_ctrl.inc_d) begin
            r_d   <= r_d + VW'(1);
            r_dsq <= r_dsq + SW'({r_d, 1'b1});
        end
    end

    // remainder unit, one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start_div) begin
            r_rem <= '0;
            r_q   <= r_v;
        end else if (i_ctrl.div_step) begin
            r_rem <= n_rem;
            r_q   <= {r_q[VW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_ctrl.start_div) begin
            r_bits <= BW'(VW);
        end else if (i_ctrl.div_step) begin
            r_bits <= r_bits - BW'(1);
        end
    end

    // flags for the sequencer
    assign o_dp_status.v_ge_hi  = (r_v >= r_hi);
    assign o_dp_status.v_lt2    = (r_v < VW'(pcr_pkg::FIRST_DIVISOR));
    assign o_dp_status.dsq_gt_v = (r_dsq > {2'b00, r_v});
    assign o_dp_status.div_more = (r_bits != BW'(1));
    assign o_dp_status.rem_nz   = (r_rem != '0);

    assign o_count = r_cnt;

    // divisions only run with a real divisor
    a_div_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_step |-> (r_d >= VW'(pcr_pkg::FIRST_DIVISOR)))
        else $error("trial division with divisor below two");

    // finished remainder is below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.div_step && r_bits == BW'(1)) |=> (r_rem < r_d))
        else $error("remainder not below divisor");

    // candidate only advances inside the range
    a_v_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.inc_v |-> (r_v < r_hi))
        else $error("candidate advanced past range end");

    // only candidates of two and above are counted
    a_cnt_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.inc_cnt |-> !o_dp_status.v_lt2)
        else $error("zero or one counted as prime");

endmodule

// ===== rtl/prime_count_in_range_top.sv =====
// each request is loaded and its result stored; per candidate the range check and the small-value test run
// and, per trial divisor tried, the square test and a division in the remainder unit over every value bit
// throughput: one request at a time; the next is taken once the result is in the output register
// the one-bit-per-cycle remainder loop of the microprogram sets the rate
// reset: synchronous, active low; clears the step counter, the remainder bit counter
// and the output valid, nothing else
module prime_count_in_range_top #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pcr_pkg::FIELD_BITS-1:0]  i_range_start,
    input  logic [pcr_pkg::FIELD_BITS-1:0]  i_range_end,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pcr_pkg::COUNT_BITS-1:0]  o_prime_count
);

    pcr_pkg::t_ctrl                  w_ctrl;
    pcr_pkg::t_dp_status             w_dp_status;
    logic                            w_idle;
    logic                            w_out_busy;
    logic [pcr_pkg::COUNT_BITS-1:0]  w_count;

    logic                            r_out_valid;
    logic [pcr_pkg::COUNT_BITS-1:0]  r_out_count;

    // request side takes only while the sequencer waits
    assign o_stall    = !w_idle;
    assign w_out_busy = r_out_valid && i_stall;

    pcr_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_out_busy  (w_out_busy),
        .i_dp_status (w_dp_status),
        .o_ctrl      (w_ctrl),
        .o_idle      (w_idle)
    );

    pcr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_dp_status   (w_dp_status),
        .o_count       (w_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_out) begin
            r_out_count <= w_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_prime_count = r_out_count;

endmodule
